>>> design/fwh_pkg.sv
// ============================================================================
// Fixed-width histogram package
// Shared widths, constants, request type, the reciprocal table and a saturating increment.
// ============================================================================
`default_nettype none

package fwh_pkg;

    localparam int SAMPLE_W    = 23;
    localparam int FRAC_BITS   = 16;
    localparam int INT_W       = SAMPLE_W - FRAC_BITS;
    localparam int IDX_W       = 7;
    localparam int MAX_BINS    = 128;
    localparam int CNT_W       = 32;
    localparam int WIDTH_W     = 6;
    localparam int NBINS_W     = 8;
    localparam int RANGE_TOP   = 100;

    // Item modes: add a sample or read one bin.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Reciprocals are ceil(2^RECIP_SHIFT / width); exact for quotients of
    // dividends below 2^INT_W and widths below 2^WIDTH_W.
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(16384);
    localparam logic [NBINS_W-1:0] NBINS_RESET = NBINS_W'(RANGE_TOP);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             hit;
    } bin_req_t;

    function automatic logic [RECIP_W-1:0] recip_lut(input logic [WIDTH_W-1:0] w);
        logic [RECIP_W-1:0] r;
        unique case (w)
            6'd0, 6'd1: r = 15'd16384;
            6'd2:  r = 15'd8192;
            6'd3:  r = 15'd5462;
            6'd4:  r = 15'd4096;
            6'd5:  r = 15'd3277;
            6'd6:  r = 15'd2731;
            6'd7:  r = 15'd2341;
            6'd8:  r = 15'd2048;
            6'd9:  r = 15'd1821;
            6'd10: r = 15'd1639;
            6'd11: r = 15'd1490;
            6'd12: r = 15'd1366;
            6'd13: r = 15'd1261;
            6'd14: r = 15'd1171;
            6'd15: r = 15'd1093;
            6'd16: r = 15'd1024;
            6'd17: r = 15'd964;
            6'd18: r = 15'd911;
            6'd19: r = 15'd863;
            6'd20: r = 15'd820;
            6'd21: r = 15'd781;
            6'd22: r = 15'd745;
            6'd23: r = 15'd713;
            6'd24: r = 15'd683;
            6'd25: r = 15'd656;
            6'd26: r = 15'd631;
            6'd27: r = 15'd607;
            6'd28: r = 15'd586;
            6'd29: r = 15'd565;
            6'd30: r = 15'd547;
            6'd31: r = 15'd529;
            6'd32: r = 15'd512;
            6'd33: r = 15'd497;
            6'd34: r = 15'd482;
            6'd35: r = 15'd469;
            6'd36: r = 15'd456;
            6'd37: r = 15'd443;
            6'd38: r = 15'd432;
            6'd39: r = 15'd421;
            6'd40: r = 15'd410;
            6'd41: r = 15'd400;
            6'd42: r = 15'd391;
            6'd43: r = 15'd382;
            6'd44: r = 15'd373;
            6'd45: r = 15'd365;
            6'd46: r = 15'd357;
            6'd47: r = 15'd349;
            6'd48: r = 15'd342;
            6'd49: r = 15'd335;
            6'd50: r = 15'd328;
            6'd51: r = 15'd322;
            6'd52: r = 15'd316;
            6'd53: r = 15'd310;
            6'd54: r = 15'd304;
            6'd55: r = 15'd298;
            6'd56: r = 15'd293;
            6'd57: r = 15'd288;
            6'd58: r = 15'd283;
            6'd59: r = 15'd278;
            6'd60: r = 15'd274;
            6'd61: r = 15'd269;
            6'd62: r = 15'd265;
            6'd63: r = 15'd261;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> design/fwh_index.sv
// ============================================================================
// Fixed-width histogram bin index
// Maps adds by reciprocal multiplication, reads by bin_select; checks range.
// ============================================================================
`default_nettype none

module fwh_index (
    input  logic                          mode,
    input  logic [fwh_pkg::SAMPLE_W-1:0]  sample,
    input  logic [fwh_pkg::IDX_W-1:0]     bin_select,
    input  logic [fwh_pkg::RECIP_W-1:0]   recip,
    input  logic [fwh_pkg::NBINS_W-1:0]   nbins,
    output fwh_pkg::bin_req_t             req
);
    import fwh_pkg::*;

    logic [INT_W-1:0]         int_part;
    logic [INT_W+RECIP_W-1:0] product;
    logic [IDX_W-1:0]         quotient;
    logic [IDX_W-1:0]         idx;

    assign int_part = sample[SAMPLE_W-1:FRAC_BITS];

    // The quotient never exceeds the integer part, so it fits the index width.
    assign product  = (INT_W+RECIP_W)'(int_part) * (INT_W+RECIP_W)'(recip);
    assign quotient = product[RECIP_SHIFT +: IDX_W];

    assign idx     = (mode == MODE_READ) ? bin_select : quotient;
    assign req.idx = idx;
    assign req.hit = NBINS_W'(idx) < nbins;

endmodule

`default_nettype wire

>>> design/fwh_count_mem.sv
// ============================================================================
// Fixed-width histogram counter memory
// Bin counters in a synchronous memory with per-entry valid bits.
// ============================================================================
`default_nettype none

module fwh_count_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [fwh_pkg::IDX_W-1:0]   rd_addr,
    output logic [fwh_pkg::CNT_W-1:0]   rd_data,
    input  logic                        wr_en,
    input  logic [fwh_pkg::IDX_W-1:0]   wr_addr,
    input  logic [fwh_pkg::CNT_W-1:0]   wr_data
);
    import fwh_pkg::*;

    logic [CNT_W-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0] entry_valid_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> design/fixed_width_histogram_unit.sv
// ============================================================================
// Fixed-width histogram unit
// Counts samples into bins of a configured width and reads bins back.
// ============================================================================
// One item is taken per clock unless a stalled output holds the update stage. Its
// result passes through the update stage into an output register; a new item is
// still taken into the update stage while a result waits, if that stage is empty.
// The counters live in a 128-entry memory with a registered read; each in-range add
// item reads its bin, increments it with saturation and writes it back as it leaves
// the update stage, and a write-to-read bypass covers an item that reads the bin
// written by the item just ahead of it. Counters start at zero after reset with
// no clearing pass. The bin width is written through cfg_we, by the user only while
// no item is in flight, which the block does not enforce; a width of zero acts as one.
`default_nettype none

module fixed_width_histogram_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fwh_pkg::WIDTH_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [fwh_pkg::SAMPLE_W-1:0]  sample,
    input  logic [fwh_pkg::IDX_W-1:0]     bin_select,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fwh_pkg::IDX_W-1:0]     bin_index,
    output logic                          counted,
    output logic [fwh_pkg::CNT_W-1:0]     bin_count,
    output logic [fwh_pkg::CNT_W-1:0]     total_count
);
    import fwh_pkg::*;

    logic [RECIP_W-1:0]         recip_reg;
    logic [RECIP_W-1:0]         recip_next;
    logic [NBINS_W-1:0]         nbins_reg;
    logic [NBINS_W-1:0]         nbins_next;
    logic [NBINS_W+RECIP_W-1:0] nbins_prod;

    bin_req_t           req;
    logic               accept;
    logic               adv;

    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_hit_reg;
    logic               bypass_reg;
    logic               bypass_next;
    logic [CNT_W-1:0]   fwd_data_reg;

    logic [CNT_W-1:0]   rd_data;
    logic [CNT_W-1:0]   old_count;
    logic [CNT_W-1:0]   new_count;
    logic               wr_en;

    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   bin_index_reg;
    logic               counted_reg;
    logic [CNT_W-1:0]   bin_count_reg;
    logic [CNT_W-1:0]   total_count_reg;

    // Bin width configuration, held as its reciprocal and the bin count.
    assign recip_next = recip_lut(cfg_wdata);
    assign nbins_prod = (NBINS_W+RECIP_W)'(RANGE_TOP) * (NBINS_W+RECIP_W)'(recip_next);
    assign nbins_next = nbins_prod[RECIP_SHIFT +: NBINS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_reg <= RECIP_RESET;
            nbins_reg <= NBINS_RESET;
        end
        else if (cfg_we)
        begin
            recip_reg <= recip_next;
            nbins_reg <= nbins_next;
        end
    end

    fwh_index u_index (
        .mode       (mode),
        .sample     (sample),
        .bin_select (bin_select),
        .recip      (recip_reg),
        .nbins      (nbins_reg),
        .req        (req)
    );

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign accept   = in_valid && in_ready;

    // Update stage: the memory read has landed, forward the last write if it
    // went to the same bin in the cycle the read was issued.
    assign old_count  = bypass_reg ? fwd_data_reg : rd_data;
    assign new_count  = sat_inc(old_count);
    assign wr_en      = adv && s1_hit_reg && (s1_mode_reg == MODE_ADD);
    assign total_next = wr_en ? sat_inc(total_reg) : total_reg;
    assign bypass_next = wr_en && (s1_idx_reg == req.idx);

    fwh_count_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (new_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            bypass_reg    <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                bypass_reg   <= bypass_next;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
                bypass_reg   <= 1'b0;
            end
            total_reg <= total_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= mode;
            s1_idx_reg  <= req.idx;
            s1_hit_reg  <= req.hit;
        end
        if (wr_en)
        begin
            fwd_data_reg <= new_count;
        end
        if (adv)
        begin
            bin_index_reg   <= s1_idx_reg;
            counted_reg     <= s1_hit_reg;
            bin_count_reg   <= !s1_hit_reg ? '0 :
                               ((s1_mode_reg == MODE_READ) ? old_count : new_count);
            total_count_reg <= total_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_index   = bin_index_reg;
    assign counted     = counted_reg;
    assign bin_count   = bin_count_reg;
    assign total_count = total_count_reg;

`ifndef SYNTH
    a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        bypass_reg |-> s1_valid_reg)
        else $error("bypass flag set with no item in the update stage");

    a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !counted_reg) |-> (bin_count_reg == '0))
        else $error("uncounted result carries a non-zero bin count");

    a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> ((total_reg != $past(total_reg)) || (total_reg == CNT_MAX)))
        else $error("counted sample did not advance the total");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ============================================================================
// Fixed-width histogram unit testbench
// Drives add and read items through the unit under random handshake pressure
// and checks every result against a cycle-free model of the bin counters.
// ============================================================================
`default_nettype none

module testbench;
    import fwh_pkg::*;

    localparam int   IDLE_PCT     = 27;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   PHASE_ITEMS  = 100;
    localparam int   NUM_PHASES   = 15;
    localparam int   REPORT_LIMIT = 10;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    bin_select;
    } hist_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic             counted;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] total_count;
    } hist_result_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [WIDTH_W-1:0]  cfg_wdata   = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                mode        = MODE_ADD;
    logic [SAMPLE_W-1:0] sample      = '0;
    logic [IDX_W-1:0]    bin_select  = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [IDX_W-1:0]    bin_index;
    logic                counted;
    logic [CNT_W-1:0]    bin_count;
    logic [CNT_W-1:0]    total_count;

    hist_item_t          pending_items[$];
    hist_result_t        expected_results[$];
    int unsigned         items_queued  = 0;
    int unsigned         results_seen  = 0;
    int unsigned         error_count   = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         hot_bin       = 0;
    bit                  steady        = 1'b0;

    // Model of the counter store and the width register.
    logic [CNT_W-1:0]    tally [MAX_BINS];
    logic [CNT_W-1:0]    tally_total   = '0;
    logic [WIDTH_W-1:0]  width_setting = WIDTH_W'(1);

    logic [WIDTH_W-1:0]  width_plan [NUM_PHASES] =
        '{6'd1, 6'd2, 6'd3, 6'd5, 6'd7, 6'd10, 6'd0, 6'd63,
          6'd50, 6'd51, 6'd13, 6'd25, 6'd33, 6'd1, 6'd1};

    fixed_width_histogram_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .sample      (sample),
        .bin_select  (bin_select),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bin_index   (bin_index),
        .counted     (counted),
        .bin_count   (bin_count),
        .total_count (total_count)
    );

    always #4 clk = ~clk;

    function automatic int unsigned bin_span();
        return (width_setting == '0) ? 1 : int'(width_setting);
    endfunction

    function automatic int unsigned bins_in_use();
        int unsigned n;
        n = RANGE_TOP / bin_span();
        return (n > MAX_BINS) ? MAX_BINS : n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] fixed_sample(input int unsigned whole,
                                                         input int unsigned frac);
        return {whole[INT_W-1:0], frac[FRAC_BITS-1:0]};
    endfunction

    // Works out the result of one item and, for an add, updates the modelled counters.
    function automatic hist_result_t histogram_result(input logic                op,
                                                      input logic [SAMPLE_W-1:0] value,
                                                      input logic [IDX_W-1:0]    sel);
        hist_result_t r;
        int unsigned  bin;
        int unsigned  nbins;
        r     = '0;
        nbins = bins_in_use();
        if (op == MODE_ADD) begin
            bin         = (value >> FRAC_BITS) / bin_span();
            r.bin_index = (bin > MAX_BINS - 1) ? IDX_W'(MAX_BINS - 1) : IDX_W'(bin);
            if (bin < nbins) begin
                if (tally[bin] != CNT_MAX)
                    tally[bin] = tally[bin] + 1'b1;
                if (tally_total != CNT_MAX)
                    tally_total = tally_total + 1'b1;
                r.counted   = 1'b1;
                r.bin_count = tally[bin];
            end
        end
        else begin
            r.bin_index = sel;
            if (sel < nbins) begin
                r.counted   = 1'b1;
                r.bin_count = tally[sel];
            end
        end
        r.total_count = tally_total;
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic queue_item(input logic                op,
                              input logic [SAMPLE_W-1:0] value,
                              input logic [IDX_W-1:0]    sel);
        hist_item_t it;
        it.mode       = op;
        it.sample     = value;
        it.bin_select = sel;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly in-range adds and reads of real bins, often hammering one bin so
    // that consecutive transfers hit the same counter; the rest are dropped
    // samples, missing bins and unconstrained noise.
    task automatic queue_random_item();
        int unsigned nbins;
        int unsigned pick;
        int unsigned bin;
        int unsigned whole;
        logic        op;
        logic [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]    sel;
        nbins = bins_in_use();
        pick  = $urandom_range(0, 9);
        bin   = (pick < 4) ? hot_bin : $urandom_range(0, nbins - 1);
        if (bin >= nbins)
            bin = nbins - 1;
        hot_bin = bin;
        whole   = bin * bin_span() + $urandom_range(0, bin_span() - 1);
        sel     = IDX_W'(bin);
        if (pick == 9) begin
            whole = $urandom_range(nbins * bin_span(), MAX_BINS - 1);
            sel   = IDX_W'($urandom_range(nbins, MAX_BINS - 1));
        end
        value = fixed_sample(whole, $urandom);
        if (pick == 8) begin
            value = SAMPLE_W'($urandom);
            sel   = IDX_W'($urandom);
        end
        op = ($urandom_range(0, 99) < 60) ? MODE_ADD : MODE_READ;
        queue_item(op, value, sel);
    endtask

    task automatic settle();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [WIDTH_W-1:0] w);
        cfg_we        <= 1'b1;
        cfg_wdata     <= w;
        width_setting  = w;
        @(posedge clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic run_phase(input logic [WIDTH_W-1:0] w, input bit sweep);
        int unsigned k;
        set_width(w);
        for (k = 0; k < PHASE_ITEMS; k++)
            queue_random_item();
        if (sweep)
            for (k = 0; k < MAX_BINS; k++)
                queue_item(MODE_READ, SAMPLE_W'($urandom), IDX_W'(k));
        settle();
    endtask

    initial begin
        int unsigned p;
        for (p = 0; p < MAX_BINS; p++)
            tally[p] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items run without gaps so that same-bin transfers are
        // back to back.
        steady = 1'b1;
        queue_item(MODE_ADD,  fixed_sample(0, 0), '0);
        queue_item(MODE_ADD,  fixed_sample(0, 0), '1);
        queue_item(MODE_ADD,  {SAMPLE_W{1'b1}}, '0);
        queue_item(MODE_ADD,  fixed_sample(99, 16'hFFFF), '0);
        queue_item(MODE_ADD,  fixed_sample(100, 0), '0);
        queue_item(MODE_ADD,  fixed_sample(0, 16'hFFFF), '0);
        queue_item(MODE_READ, '0, IDX_W'(0));
        queue_item(MODE_READ, '1, IDX_W'(99));
        queue_item(MODE_READ, '0, IDX_W'(100));
        queue_item(MODE_READ, '0, {IDX_W{1'b1}});
        queue_item(MODE_READ, '0, IDX_W'(50));
        queue_item(MODE_ADD,  fixed_sample(99, 0), '0);
        queue_item(MODE_READ, '0, IDX_W'(99));
        settle();

        // A zero width behaves as a width of one.
        set_width(6'd0);
        queue_item(MODE_ADD,  fixed_sample(99, 0), '0);
        queue_item(MODE_READ, '0, IDX_W'(99));
        queue_item(MODE_ADD,  fixed_sample(100, 0), '0);
        settle();

        // Two bins: bin 99 is hidden but keeps its count.
        set_width(6'd50);
        queue_item(MODE_ADD,  fixed_sample(99, 0), '0);
        queue_item(MODE_ADD,  fixed_sample(100, 0), '0);
        queue_item(MODE_READ, '0, IDX_W'(99));
        queue_item(MODE_READ, '0, IDX_W'(1));
        settle();

        set_width({WIDTH_W{1'b1}});
        queue_item(MODE_ADD,  {SAMPLE_W{1'b1}}, '0);
        queue_item(MODE_ADD,  fixed_sample(62, 0), '0);
        queue_item(MODE_READ, '0, IDX_W'(1));
        settle();

        set_width(6'd1);
        queue_item(MODE_READ, '0, IDX_W'(99));
        queue_item(MODE_READ, '0, IDX_W'(1));
        settle();
        steady = 1'b0;

        for (p = 0; p < NUM_PHASES; p++) begin
            steady = (p == 5);
            run_phase((p >= NUM_PHASES - 2) ? WIDTH_W'($urandom_range(0, 63)) : width_plan[p],
                      (p == 0) || (p == NUM_PHASES - 1));
        end

        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Input driver: a held transfer stays put until it is taken.
    always @(posedge clk or negedge rst_n) begin
        hist_item_t next_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready) begin
            if (pending_items.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item   = pending_items.pop_front();
                in_valid   <= 1'b1;
                mode       <= next_item.mode;
                sample     <= next_item.sample;
                bin_select <= next_item.bin_select;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: predicts on each input transfer, checks on each output transfer.
    always @(posedge clk) begin
        hist_result_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_results.push_back(histogram_result(mode, sample, bin_select));
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result bin_index %0d counted %0d",
                                           bin_index, counted));
                end
                else begin
                    want = expected_results.pop_front();
                    if (bin_index !== want.bin_index || counted !== want.counted ||
                        bin_count !== want.bin_count || total_count !== want.total_count)
                        report_error($sformatf(
                            "bin_index %0d/%0d counted %0d/%0d bin_count %0d/%0d total %0d/%0d",
                            want.bin_index, bin_index, want.counted, counted,
                            want.bin_count, bin_count, want.total_count, total_count));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

`default_nettype wire

>>> files.f
design/fwh_pkg.sv
design/fwh_index.sv
design/fwh_count_mem.sv
design/fixed_width_histogram_unit.sv
verif/testbench.sv
